### rtl/core/ifc_pkg.sv
// Package for the integer full convolution block.
// Holds the field widths, action codes, controller states and the command/status structs.
// No dependencies.
package ifc_pkg;

    localparam int DATA_W   = 32;
    localparam int IDX_W    = 6;
    localparam int ELEM_W   = 5;
    localparam int ACT_W    = 2;
    localparam int LEN_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CAP_LEN  = 32;

    localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_B = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             issue;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] b_addr;
        logic             emit;
        logic [IDX_W-1:0] out_index;
        logic             out_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/ifc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ifc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/ifc_dp.sv
// Datapath: sequence stores, multiplier, accumulator and output register.
// Depends on ifc_pkg and ifc_ram.
module ifc_dp #(
    parameter int MAX_LEN_A = 32,
    parameter int MAX_LEN_B = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ifc_pkg::t_cmd                    i_cmd,
    output ifc_pkg::t_sts                    o_sts,
    input  logic [ifc_pkg::ELEM_W-1:0]       i_elem_index,
    input  logic signed [ifc_pkg::DATA_W-1:0] i_elem_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ifc_pkg::IDX_W-1:0]        o_out_index,
    output logic signed [ifc_pkg::DATA_W-1:0] o_out_value,
    output logic                             o_out_last
);
    import ifc_pkg::*;

    localparam int AW_A = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
    localparam int AW_B = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;

    logic              wr_a;
    logic              wr_b;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;

    logic              r_s1_vld, r_s1_first, r_s1_last;
    logic              r_s2_vld, r_s2_first, r_s2_last;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_done;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_last;

    // Drop loads whose index lies beyond the store depth
    assign wr_a = i_cmd.load_a && (32'(i_elem_index) < MAX_LEN_A);
    assign wr_b = i_cmd.load_b && (32'(i_elem_index) < MAX_LEN_B);

    ifc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN_A)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (AW_A'(i_elem_index)),
        .i_wr_data (i_elem_value),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (AW_A'(i_cmd.a_addr)),
        .o_rd_data (rd_a)
    );

    ifc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN_B)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (AW_B'(i_elem_index)),
        .i_wr_data (i_elem_value),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (AW_B'(i_cmd.b_addr)),
        .o_rd_data (rd_b)
    );

    // Pipeline flags: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        // Low half of the product is the same for signed and unsigned operands
        r_prod     <= DATA_W'(rd_a * rd_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_s2_first ? r_prod : r_acc + r_prod;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_index <= i_cmd.out_index;
            r_out_value <= r_acc;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_sts.acc_done = r_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

### rtl/core/ifc_ctrl.sv
// Controller: length registers, input handshake and the sequencer over (k, i) terms.
// Depends on ifc_pkg.
module ifc_ctrl #(
    parameter int MAX_LEN_A = 32,
    parameter int MAX_LEN_B = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ifc_pkg::ACT_W-1:0]     i_action,
    input  logic                          i_cfg_valid,
    input  logic [ifc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ifc_pkg::LEN_W-1:0]     i_cfg_data,
    output ifc_pkg::t_cmd                 o_cmd,
    input  ifc_pkg::t_sts                 i_sts
);
    import ifc_pkg::*;

    localparam int LIM_A = (MAX_LEN_A < CAP_LEN) ? MAX_LEN_A : CAP_LEN;
    localparam int LIM_B = (MAX_LEN_B < CAP_LEN) ? MAX_LEN_B : CAP_LEN;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_len_a, r_len_b;
    logic [IDX_W-1:0] r_la, n_la;
    logic [IDX_W-1:0] r_lb, n_lb;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_k_end, n_k_end;
    logic [IDX_W-1:0] clamp_a, clamp_b;
    logic [IDX_W-1:0] i_lo, i_hi;
    logic             accept;

    // Clamp lengths: zero becomes one, large values saturate
    always_comb begin
        if (r_len_a == '0) begin
            clamp_a = IDX_W'(1);
        end else if (32'(r_len_a) > LIM_A) begin
            clamp_a = IDX_W'(LIM_A);
        end else begin
            clamp_a = IDX_W'(r_len_a);
        end
        if (r_len_b == '0) begin
            clamp_b = IDX_W'(1);
        end else if (32'(r_len_b) > LIM_B) begin
            clamp_b = IDX_W'(LIM_B);
        end else begin
            clamp_b = IDX_W'(r_len_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= LEN_W'(1);
            r_len_b <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEN_A: r_len_a <= i_cfg_data;
                REG_LEN_B: r_len_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Term range for result k
    assign i_lo = (r_k >= r_lb) ? r_k + IDX_W'(1) - r_lb : '0;
    assign i_hi = (r_k < r_la) ? r_k : r_la - IDX_W'(1);

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la    <= n_la;
        r_lb    <= n_lb;
        r_k     <= n_k;
        r_i     <= n_i;
        r_k_end <= n_k_end;
    end

    always_comb begin
        n_state = r_state;
        n_la    = r_la;
        n_lb    = r_lb;
        n_k     = r_k;
        n_i     = r_i;
        n_k_end = r_k_end;

        o_cmd           = '0;
        o_cmd.a_addr    = r_i;
        o_cmd.b_addr    = r_k - r_i;
        o_cmd.first     = (r_i == i_lo);
        o_cmd.last      = (r_i == i_hi);
        o_cmd.out_index = r_k;
        o_cmd.out_last  = (r_k == r_k_end);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_a = (i_action == ACT_LOAD_A);
                    o_cmd.load_b = (i_action == ACT_LOAD_B);
                    if (i_action == ACT_COMPUTE) begin
                        n_la    = clamp_a;
                        n_lb    = clamp_b;
                        n_k     = '0;
                        n_k_end = IDX_W'(7'(clamp_a) + 7'(clamp_b) - 7'd2);
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_i     = i_lo;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (r_i == i_hi) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (i_sts.acc_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_k == r_k_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_SETUP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/integer_full_convolution.sv
// Sequence: a load writes its element in its transfer. A compute then, for each result k with
// n_k terms, runs a setup, issues the n_k terms, drains the pipeline and emits the result;
// an emit waits while an untaken result holds the output. The shared read-multiply-accumulate
// pipeline takes one term per cycle. Each result shows in the cycle after its emit.
// One item at a time: a load leaves the input ready, a compute frees it after its last emit.
// Reset (i_rst_n, synchronous, active low): controller idle, output empty, both lengths 1,
// accumulator zero; the sequence stores are not cleared and hold nothing until loaded.
// Top level of the integer full convolution block.
// Depends on ifc_pkg, ifc_ram, ifc_dp and ifc_ctrl.
module integer_full_convolution #(
    parameter int MAX_LEN_A = 32,
    parameter int MAX_LEN_B = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ifc_pkg::ACT_W-1:0]         i_action,
    input  logic [ifc_pkg::ELEM_W-1:0]        i_elem_index,
    input  logic signed [ifc_pkg::DATA_W-1:0] i_elem_value,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ifc_pkg::IDX_W-1:0]         o_out_index,
    output logic signed [ifc_pkg::DATA_W-1:0] o_out_value,
    output logic                              o_out_last,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ifc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ifc_pkg::LEN_W-1:0]         i_cfg_data
);
    import ifc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Take every configuration transfer at once
    assign o_cfg_ready = 1'b1;

    // Sequencer: owns the lengths, the input handshake and the term order
    ifc_ctrl #(
        .MAX_LEN_A (MAX_LEN_A),
        .MAX_LEN_B (MAX_LEN_B)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath: stores, product, running sum and the result register that
    // lets the next result's terms proceed while the last one waits
    ifc_dp #(
        .MAX_LEN_A (MAX_LEN_A),
        .MAX_LEN_B (MAX_LEN_B)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_out_last   (o_out_last)
    );

    // Emit only into a free result register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result emitted over an untaken result");

    // The final result of a run shows up flagged in the next cycle
    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.out_last) |=> (o_out_valid && o_out_last))
        else $error("final result not flagged at the output");

    // A finished sum never coincides with a new term issue
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.acc_done |-> !cmd.issue)
        else $error("term issued while a sum completes");

    // No input transfer while terms are in flight
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !(cmd.issue || sts.acc_done))
        else $error("input transfer during a compute run");

endmodule
